### rtl/lcgr_pkg.sv
// lcgr_pkg: shared constants and sequencer state type for the ranged lcg block
// no dependencies
package lcgr_pkg;

    localparam logic [63:0] LCG_MUL  = 64'h5D588B656C078965;
    localparam logic [63:0] LCG_ADD  = 64'h0000000000269EC3;
    localparam logic [32:0] WORD_DIV = 33'h0FFFFFFFF;

    localparam logic [1:0] MODE_RAW   = 2'd0;
    localparam logic [1:0] MODE_BOUND = 2'd1;
    localparam logic [1:0] MODE_RANGE = 2'd2;
    localparam logic [1:0] MODE_SEED  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_LL,
        ST_MUL_HL,
        ST_MUL_LH,
        ST_ADD,
        ST_SCALE,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } seq_state_t;

endpackage

### rtl/lcgr_mul32.sv
// lcgr_mul32: shared 32x32 unsigned multiplier with registered product
// depends on nothing
module lcgr_mul32 (
    input  logic        aclk,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [63:0] prod_reg
);

    logic [63:0] prod_next;

    assign prod_next = {32'd0, op_a} * {32'd0, op_b};

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule

### rtl/lcg64_ranged_random.sv
// lcg64_ranged_random: 64-bit lcg with raw, bounded, ranged and seed-load modes
// depends on lcgr_pkg and lcgr_mul32
// from accept, a seed load or a non-positive bound goes straight to the output state;
// a raw word passes mul_ll, mul_hl, mul_lh and add; bounded or ranged adds scale, div, fin
// one item at a time; s_ready returns the cycle after the result is taken
// all work goes through one registered 32x32 multiplier (three partial products
// for the state update, one for the scale); aresetn clears the state to zero
module lcg64_ranged_random (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [63:0] s_seed_value,
    input  logic signed [31:0] s_range_low,
    input  logic signed [31:0] s_range_high,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_raw_word,
    output logic signed [31:0] m_ranged_value,
    output logic [63:0] m_state_now
);

    lcgr_pkg::seq_state_t st_reg, st_next;

    logic [63:0] gen_reg, gen_next;
    logic [1:0]  mode_reg, mode_next;
    logic [31:0] lo_reg, lo_next;
    logic [31:0] bound_reg, bound_next;
    logic [31:0] word_reg, word_next;
    logic [31:0] ranged_reg, ranged_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] cross_reg, cross_next;
    logic [31:0] q_reg, q_next;

    logic [31:0] op_a, op_b;
    logic [63:0] prod_reg;

    logic [31:0] in_bound;
    logic        in_bad;
    logic [63:0] upd_state;
    logic [32:0] div_rem;
    logic [31:0] q_clamped;

    lcgr_mul32 u_mul (
        .aclk     (aclk),
        .op_a     (op_a),
        .op_b     (op_b),
        .prod_reg (prod_reg)
    );

    assign in_bound = (s_mode == lcgr_pkg::MODE_BOUND) ? s_range_high
                    : (s_range_high - s_range_low + 32'd1);
    assign in_bad   = (in_bound == 32'd0) || in_bound[31];

    assign upd_state = acc_reg + {cross_reg + prod_reg[31:0], 32'd0} + lcgr_pkg::LCG_ADD;
    assign div_rem   = {1'b0, prod_reg[31:0]} + {1'b0, prod_reg[63:32]};
    assign q_clamped = (q_reg >= bound_reg) ? (bound_reg - 32'd1) : q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= lcgr_pkg::ST_IDLE;
            gen_reg <= 64'd0;
        end else begin
            st_reg  <= st_next;
            gen_reg <= gen_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg   <= mode_next;
        lo_reg     <= lo_next;
        bound_reg  <= bound_next;
        word_reg   <= word_next;
        ranged_reg <= ranged_next;
        acc_reg    <= acc_next;
        cross_reg  <= cross_next;
        q_reg      <= q_next;
    end

    always_comb begin
        st_next     = st_reg;
        gen_next    = gen_reg;
        mode_next   = mode_reg;
        lo_next     = lo_reg;
        bound_next  = bound_reg;
        word_next   = word_reg;
        ranged_next = ranged_reg;
        acc_next    = acc_reg;
        cross_next  = cross_reg;
        q_next      = q_reg;
        op_a        = gen_reg[31:0];
        op_b        = lcgr_pkg::LCG_MUL[31:0];
        s_ready     = 1'b0;
        m_valid     = 1'b0;

        unique case (st_reg)
            lcgr_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    mode_next   = s_mode;
                    lo_next     = s_range_low;
                    bound_next  = in_bound;
                    word_next   = 32'd0;
                    ranged_next = 32'd0;
                    priority if (s_mode == lcgr_pkg::MODE_SEED) begin
                        gen_next = s_seed_value;
                        st_next  = lcgr_pkg::ST_OUT;
                    end else if (s_mode != lcgr_pkg::MODE_RAW && in_bad) begin
                        if (s_mode == lcgr_pkg::MODE_RANGE) begin
                            ranged_next = s_range_low;
                        end
                        st_next = lcgr_pkg::ST_OUT;
                    end else begin
                        st_next = lcgr_pkg::ST_MUL_LL;
                    end
                end
            end
            lcgr_pkg::ST_MUL_LL: begin
                op_a    = gen_reg[31:0];
                op_b    = lcgr_pkg::LCG_MUL[31:0];
                st_next = lcgr_pkg::ST_MUL_HL;
            end
            lcgr_pkg::ST_MUL_HL: begin
                op_a     = gen_reg[63:32];
                op_b     = lcgr_pkg::LCG_MUL[31:0];
                acc_next = prod_reg;
                st_next  = lcgr_pkg::ST_MUL_LH;
            end
            lcgr_pkg::ST_MUL_LH: begin
                op_a       = gen_reg[31:0];
                op_b       = lcgr_pkg::LCG_MUL[63:32];
                cross_next = prod_reg[31:0];
                st_next    = lcgr_pkg::ST_ADD;
            end
            lcgr_pkg::ST_ADD: begin
                gen_next  = upd_state;
                word_next = upd_state[63:32];
                if (mode_reg == lcgr_pkg::MODE_RAW) begin
                    st_next = lcgr_pkg::ST_OUT;
                end else begin
                    st_next = lcgr_pkg::ST_SCALE;
                end
            end
            lcgr_pkg::ST_SCALE: begin
                op_a    = bound_reg;
                op_b    = word_reg;
                st_next = lcgr_pkg::ST_DIV;
            end
            lcgr_pkg::ST_DIV: begin
                // divide by 2^32-1: quotient estimate is the high word, one correction
                if (div_rem >= lcgr_pkg::WORD_DIV) begin
                    q_next = prod_reg[63:32] + 32'd1;
                end else begin
                    q_next = prod_reg[63:32];
                end
                st_next = lcgr_pkg::ST_FIN;
            end
            lcgr_pkg::ST_FIN: begin
                if (mode_reg == lcgr_pkg::MODE_RANGE) begin
                    ranged_next = q_clamped + lo_reg;
                end else begin
                    ranged_next = q_clamped;
                end
                st_next = lcgr_pkg::ST_OUT;
            end
            lcgr_pkg::ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    st_next = lcgr_pkg::ST_IDLE;
                end
            end
            default: begin
                st_next = lcgr_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_raw_word     = word_reg;
    assign m_ranged_value = ranged_reg;
    assign m_state_now    = gen_reg;

endmodule

### sim/tb_lcg64_ranged_random.sv
// tb_lcg64_ranged_random: self-checking testbench for the ranged 64-bit lcg block
// depends on lcgr_pkg and lcg64_ranged_random; predicts every result item in place
// directed corner items first, then random items, first steady, then with random gaps and stalls
module tb_lcg64_ranged_random;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] raw_word;
        logic [31:0] ranged_value;
        logic [63:0] state_now;
    } lcg_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_mode = lcgr_pkg::MODE_RAW;
    logic [63:0]        s_seed_value = '0;
    logic signed [31:0] s_range_low = '0;
    logic signed [31:0] s_range_high = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [31:0]        m_raw_word;
    logic signed [31:0] m_ranged_value;
    logic [63:0]        m_state_now;

    logic [63:0]        gen_state = '0;
    lcg_result_t        awaited_results[$];
    int                 errors = 0;
    int                 stall_left = 0;
    bit                 steady = 1'b0;

    lcg64_ranged_random uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_seed_value   (s_seed_value),
        .s_range_low    (s_range_low),
        .s_range_high   (s_range_high),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_raw_word     (m_raw_word),
        .m_ranged_value (m_ranged_value),
        .m_state_now    (m_state_now)
    );

    always #2 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // loads or advances the generator copy (not for a non-positive bound) and works out the item's result
    function automatic lcg_result_t predict_lcg(input logic [1:0] mode, input logic [63:0] seed,
                                                input logic [31:0] lo, input logic [31:0] hi);
        lcg_result_t r;
        logic [31:0] bound;
        logic [63:0] scaled;
        bit          bounded_mode;
        r = '0;
        bounded_mode = (mode == lcgr_pkg::MODE_BOUND) || (mode == lcgr_pkg::MODE_RANGE);
        bound = (mode == lcgr_pkg::MODE_RANGE) ? hi - lo + 32'd1 : hi;
        if (mode == lcgr_pkg::MODE_SEED) begin
            gen_state = seed;
        end else if (mode == lcgr_pkg::MODE_RAW || (bound != 32'd0 && !bound[31])) begin
            gen_state = gen_state * lcgr_pkg::LCG_MUL + lcgr_pkg::LCG_ADD;
            r.raw_word = gen_state[63:32];
            if (bounded_mode) begin
                scaled = ({32'd0, bound} * {32'd0, r.raw_word})
                       / {31'd0, lcgr_pkg::WORD_DIV};
                if (scaled >= {32'd0, bound}) begin
                    scaled = {32'd0, bound} - 64'd1;
                end
                r.ranged_value = scaled[31:0];
            end
        end
        if (mode == lcgr_pkg::MODE_RANGE) begin
            r.ranged_value = r.ranged_value + lo;
        end
        r.state_now = gen_state;
        return r;
    endfunction

    // state that advances to the given next state
    function automatic logic [63:0] seed_before(input logic [63:0] next_state);
        logic [63:0] inv;
        inv = lcgr_pkg::LCG_MUL;
        repeat (5) begin
            inv = inv * (64'd2 - lcgr_pkg::LCG_MUL * inv);
        end
        return (next_state - lcgr_pkg::LCG_ADD) * inv;
    endfunction

    function automatic logic [31:0] edge_value();
        unique case ($urandom_range(0, 4))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'hFFFF_FFFF;
            3: return 32'h8000_0000;
            default: return 32'h7FFF_FFFF;
        endcase
    endfunction

    task automatic send_item(input logic [1:0] mode, input logic [63:0] seed,
                             input logic [31:0] lo, input logic [31:0] hi);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_mode       <= mode;
        s_seed_value <= seed;
        s_range_low  <= lo;
        s_range_high <= hi;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        awaited_results.push_back(predict_lcg(mode, seed, lo, hi));
    endtask

    // result side: compare each item, then decide the next ready
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected item raw %h ranged %h state %h", $time,
                             m_raw_word, m_ranged_value, m_state_now);
                    errors++;
                end else begin
                    lcg_result_t exp_r;
                    exp_r = awaited_results.pop_front();
                    if (m_raw_word !== exp_r.raw_word) begin
                        $display("%0t: raw_word expected %h got %h", $time,
                                 exp_r.raw_word, m_raw_word);
                        errors++;
                    end
                    if (m_ranged_value !== exp_r.ranged_value) begin
                        $display("%0t: ranged_value expected %h got %h", $time,
                                 exp_r.ranged_value, m_ranged_value);
                        errors++;
                    end
                    if (m_state_now !== exp_r.state_now) begin
                        $display("%0t: state_now expected %h got %h", $time,
                                 exp_r.state_now, m_state_now);
                        errors++;
                    end
                end
            end
            if (steady) begin
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                stall_left = pick_gap();
                m_ready <= (stall_left == 0);
            end
        end
    end

    task automatic test_reset_state();
        send_item(lcgr_pkg::MODE_RAW, {$urandom, $urandom}, $urandom, $urandom);
        send_item(lcgr_pkg::MODE_BOUND, {$urandom, $urandom}, $urandom, 32'd1);
    endtask

    task automatic test_bound_limits();
        send_item(lcgr_pkg::MODE_BOUND, {$urandom, $urandom}, $urandom, 32'h0000_0000);
        send_item(lcgr_pkg::MODE_BOUND, {$urandom, $urandom}, $urandom, 32'hFFFF_FFFF);
        send_item(lcgr_pkg::MODE_BOUND, {$urandom, $urandom}, $urandom, 32'h8000_0000);
        send_item(lcgr_pkg::MODE_BOUND, {$urandom, $urandom}, $urandom, 32'h0000_0001);
        send_item(lcgr_pkg::MODE_BOUND, {$urandom, $urandom}, $urandom, 32'h7FFF_FFFF);
        send_item(lcgr_pkg::MODE_BOUND, {$urandom, $urandom}, $urandom, 32'h0000_0002);
    endtask

    task automatic test_range_limits();
        send_item(lcgr_pkg::MODE_RANGE, {$urandom, $urandom}, 32'd5, 32'd5);
        send_item(lcgr_pkg::MODE_RANGE, {$urandom, $urandom}, 32'd6, 32'd5);
        send_item(lcgr_pkg::MODE_RANGE, {$urandom, $urandom}, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(lcgr_pkg::MODE_RANGE, {$urandom, $urandom}, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_item(lcgr_pkg::MODE_RANGE, {$urandom, $urandom}, 32'h0000_0000, 32'h7FFF_FFFE);
        send_item(lcgr_pkg::MODE_RANGE, {$urandom, $urandom}, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(lcgr_pkg::MODE_RANGE, {$urandom, $urandom}, 32'h8000_0000, 32'hFFFF_FFFF);
    endtask

    // seed loads at the extremes and a word of all ones to hit the clamp
    task automatic test_seed_and_clamp();
        logic [63:0] clamp_seed;
        clamp_seed = seed_before(64'hFFFF_FFFF_0000_0000);
        send_item(lcgr_pkg::MODE_SEED, 64'hFFFF_FFFF_FFFF_FFFF, $urandom, $urandom);
        send_item(lcgr_pkg::MODE_RAW, {$urandom, $urandom}, $urandom, $urandom);
        send_item(lcgr_pkg::MODE_SEED, 64'h0, $urandom, $urandom);
        send_item(lcgr_pkg::MODE_SEED, clamp_seed, $urandom, $urandom);
        send_item(lcgr_pkg::MODE_BOUND, {$urandom, $urandom}, $urandom, 32'h7FFF_FFFF);
        send_item(lcgr_pkg::MODE_SEED, clamp_seed, $urandom, $urandom);
        send_item(lcgr_pkg::MODE_RANGE, {$urandom, $urandom}, -32'sd10, 32'sd10);
    endtask

    task automatic run_random(input int count);
        logic [1:0]  mode;
        logic [31:0] lo;
        logic [31:0] hi;
        int          kind;
        repeat (count) begin
            mode = ($urandom_range(0, 9) == 0) ? lcgr_pkg::MODE_SEED
                                                : 2'($urandom_range(0, 2));
            kind = $urandom_range(0, 9);
            lo = $urandom;
            hi = $urandom;
            if (kind < 4) begin
                lo = $urandom_range(0, 2000) - 32'd1000;
                hi = lo + $urandom_range(0, 3000);
            end else if (kind < 6) begin
                hi = $urandom_range(1, 32'h7FFF_FFFF);
                lo = hi - $urandom_range(0, 32'h7FFF_FFFE);
            end else if (kind == 6) begin
                lo = edge_value();
                hi = edge_value();
            end
            send_item(mode, {$urandom, $urandom}, lo, hi);
        end
    endtask

    task automatic test_random_steady();
        steady = 1'b1;
        run_random(120);
        steady = 1'b0;
    endtask

    task automatic test_random_gappy();
        run_random(480);
    endtask

    initial begin
        int waited;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_bound_limits();
        test_range_limits();
        test_seed_and_clamp();
        test_random_steady();
        test_random_gappy();
        s_valid <= 1'b0;
        waited = 0;
        while (awaited_results.size() > 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (20) @(posedge aclk);
        if (awaited_results.size() > 0) begin
            $display("%0t: %0d items never arrived", $time, awaited_results.size());
            errors++;
        end
        if (errors == 0) begin
            $display("lcg64_ranged_random: match");
        end else begin
            $display("lcg64_ranged_random: mismatch");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("lcg64_ranged_random: mismatch");
        $finish;
    end

endmodule
